FILE: rtl/source_text_tokenizer_assert.svh
// Assertion macros shared by the tokenizer RTL.
// Each macro expands to one labeled concurrent assertion with a reset disable.
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// Same-cycle implication.
`define STT_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication.
`define STT_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: rtl/stt_pkg.sv
// Shared types and constants of the source text tokenizer.
// Used by the front, the bundle queue, the result stage and the top level.
`timescale 1ns / 1ps

package stt_pkg;

   localparam int MAX_EVENTS = 6;
   localparam int COUNT_W    = $clog2(MAX_EVENTS + 1);
   localparam int IDX_W      = $clog2(MAX_EVENTS);

   localparam logic [1:0] KIND_WORD_CHAR = 2'd0;
   localparam logic [1:0] KIND_WORD_END  = 2'd1;
   localparam logic [1:0] KIND_OPERATOR  = 2'd2;
   localparam logic [1:0] KIND_EOL       = 2'd3;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic [15:0] POS_MAX = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  first_char;
      logic [7:0]  second_char;
      logic [15:0] column;
      logic [15:0] line;
   } event_type;

   // All results caused by one accepted input byte, in order.
   typedef struct packed {
      logic [COUNT_W-1:0]              count;
      event_type [MAX_EVENTS-1:0]      events;
   } bundle_type;

endpackage

FILE: rtl/stt_front.sv
// Front of the tokenizer: accepts bytes, classifies them against the held
// lookahead byte and produces one bundle of events per byte. Uses stt_pkg.
`timescale 1ns / 1ps

module stt_front import stt_pkg::*; #(
   parameter int TAB_WIDTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] byte_value,
   input  logic       end_of_input,
   output logic       push,
   output bundle_type push_data
);

   // The phase holds (column - 1) modulo the tab width so tabs need no divider.
   localparam int PW = $clog2(TAB_WIDTH + 2);
   localparam logic [PW-1:0] TAB_P     = PW'(TAB_WIDTH);
   localparam logic [PW-1:0] SAT_PHASE = PW'((65535 - 1) % TAB_WIDTH);

   typedef struct packed {
      logic [7:0]    held_byte;
      logic          held_valid;
      logic          line_comment;
      logic          block_comment;
      logic          in_quotes;
      logic          word_open;
      logic [15:0]   line_count;
      logic [15:0]   column_count;
      logic [15:0]   word_start;
      logic [PW-1:0] phase;
   } front_state_type;

   typedef struct packed {
      front_state_type st;
      bundle_type      bundle;
      logic            pair_taken;
   } work_type;

   front_state_type state_ff, state_in;
   work_type        w;

   function automatic front_state_type reset_state();
      front_state_type s;
      s = '0;
      s.line_count   = 16'd1;
      s.column_count = 16'd1;
      s.word_start   = 16'd1;
      return s;
   endfunction

   function automatic work_type put(work_type wi, logic [1:0] kind, logic [7:0] a,
                                    logic [7:0] b, logic [15:0] col, logic [15:0] ln);
      work_type r;
      r = wi;
      if (r.bundle.count < COUNT_W'(MAX_EVENTS)) begin
         r.bundle.events[IDX_W'(r.bundle.count)] = '{kind, a, b, col, ln};
         r.bundle.count = r.bundle.count + COUNT_W'(1);
      end
      return r;
   endfunction

   function automatic work_type col_add(work_type wi, logic [4:0] k, logic tab);
      work_type     r;
      logic [16:0]  sum;
      logic [PW-1:0] p;
      r   = wi;
      sum = {1'b0, r.st.column_count} + {12'd0, k};
      p   = r.st.phase + PW'(k);
      if (p >= TAB_P) p = p - TAB_P;
      if (p >= TAB_P) p = p - TAB_P;
      if (tab) p = '0;
      if (sum > {1'b0, POS_MAX}) begin
         r.st.column_count = POS_MAX;
         r.st.phase        = SAT_PHASE;
      end else begin
         r.st.column_count = sum[15:0];
         r.st.phase        = p;
      end
      return r;
   endfunction

   function automatic work_type col_step(work_type wi, logic [7:0] c);
      work_type r;
      if (c == CHAR_TAB) begin
         r = col_add(wi, 5'(TAB_WIDTH) - 5'(wi.st.phase), 1'b1);
      end else begin
         r = col_add(wi, 5'd1, 1'b0);
      end
      return r;
   endfunction

   function automatic work_type end_word(work_type wi);
      work_type r;
      r = wi;
      if (r.st.word_open) begin
         r = put(r, KIND_WORD_END, CHAR_NUL, CHAR_NUL, r.st.word_start, r.st.line_count);
         r.st.word_open = 1'b0;
      end
      return r;
   endfunction

   function automatic logic is_pair(logic [7:0] a, logic [7:0] b);
      logic res;
      if (b == "=") begin
         res = a inside {"=", "!", "+", "-", "*", "/", "&", "|", ">", "<"};
      end else if (a == b) begin
         res = a inside {"&", "|", "+", "-", ">", "<"};
      end else begin
         res = (a == "-") && (b == ">");
      end
      return res;
   endfunction

   function automatic logic is_single(logic [7:0] a);
      return a inside {"{", "}", "(", ")", "[", "]", ">", "<", ",", ";", ":",
                       "+", "-", "*", "/", "%", "&", "|", "!", "~", "=", "?"};
   endfunction

   function automatic work_type classify(work_type wi, logic [7:0] c0, logic [7:0] c1);
      work_type r;
      logic     done;
      r = wi;
      r.pair_taken = 1'b0;
      done = 1'b0;
      if (c0 == CHAR_CR && c1 == CHAR_LF) begin
         r = end_word(r);
         r = put(r, KIND_EOL, CHAR_NUL, CHAR_NUL, 16'd0, 16'd0);
         if (r.st.line_count != POS_MAX) r.st.line_count = r.st.line_count + 16'd1;
         r.st.column_count = 16'd1;
         r.st.phase        = '0;
         r.st.line_comment = 1'b0;
         r.pair_taken      = 1'b1;
      end else if (c0 == CHAR_STAR && c1 == CHAR_SLASH) begin
         r = col_add(r, 5'd2, 1'b0);
         r.st.block_comment = 1'b0;
         r.pair_taken       = 1'b1;
      end else if (r.st.line_comment || r.st.block_comment) begin
         r = col_step(r, c0);
      end else if (c0 == CHAR_SLASH && (c1 == CHAR_SLASH || c1 == CHAR_STAR)) begin
         r = col_add(r, 5'd2, 1'b0);
         if (c1 == CHAR_SLASH) r.st.line_comment = 1'b1;
         else r.st.block_comment = 1'b1;
         r.pair_taken = 1'b1;
      end else begin
         if (c0 == CHAR_QUOTE) begin
            r.st.in_quotes = !r.st.in_quotes;
            if (!r.st.in_quotes) begin
               // A closing quote belongs to the word and then ends it.
               r.st.word_open = 1'b1;
               r = put(r, KIND_WORD_CHAR, c0, CHAR_NUL, r.st.word_start, r.st.line_count);
               r = end_word(r);
               r = col_add(r, 5'd1, 1'b0);
               done = 1'b1;
            end
         end
         if (!done && !r.st.in_quotes) begin
            if (c0 == CHAR_SPACE || c0 == CHAR_TAB) begin
               r = end_word(r);
               r = col_step(r, c0);
               done = 1'b1;
            end else if (is_pair(c0, c1)) begin
               r = end_word(r);
               r = put(r, KIND_OPERATOR, c0, c1, r.st.column_count, r.st.line_count);
               r = col_add(r, 5'd2, 1'b0);
               r.pair_taken = 1'b1;
               done = 1'b1;
            end else if (is_single(c0)) begin
               r = end_word(r);
               r = put(r, KIND_OPERATOR, c0, CHAR_NUL, r.st.column_count, r.st.line_count);
               r = col_add(r, 5'd1, 1'b0);
               done = 1'b1;
            end
         end
         if (!done) begin
            if (!r.st.word_open) begin
               r.st.word_start = r.st.column_count;
               r.st.word_open  = 1'b1;
            end
            r = put(r, KIND_WORD_CHAR, c0, CHAR_NUL, r.st.word_start, r.st.line_count);
            r = col_step(r, c0);
         end
      end
      return r;
   endfunction

   always_comb begin
      w.st         = state_ff;
      w.bundle     = '0;
      w.pair_taken = 1'b0;
      if (state_ff.held_valid) begin
         w = classify(w, state_ff.held_byte, byte_value);
         if (w.pair_taken) w.st.held_valid = 1'b0;
         else w.st.held_byte = byte_value;
      end else begin
         w.st.held_byte  = byte_value;
         w.st.held_valid = 1'b1;
      end
      if (end_of_input) begin
         // Drain the lookahead with no successor, flush and start a fresh text.
         if (w.st.held_valid) w = classify(w, w.st.held_byte, CHAR_NUL);
         w = end_word(w);
         w = put(w, KIND_EOL, CHAR_NUL, CHAR_NUL, 16'd0, 16'd0);
         w.st = reset_state();
      end
   end

   assign state_in  = accept ? w.st : state_ff;
   assign push      = accept && (w.bundle.count != '0);
   assign push_data = w.bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= reset_state();
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/stt_queue.sv
// Short queue of event bundles between the tokenizer front and result stage.
// Register-based ring buffer; uses bundle_type from stt_pkg.
`timescale 1ns / 1ps

module stt_queue import stt_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   output logic       full,
   input  logic       pop,
   output bundle_type head,
   output logic       empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/stt_back.sv
// Result stage of the tokenizer: takes bundles from the queue and presents
// their events one transfer at a time. Uses stt_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "source_text_tokenizer_assert.svh"

module stt_back import stt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  bundle_type  q_head,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_first_char,
   output logic [7:0]  rsp_second_char,
   output logic [15:0] rsp_column,
   output logic [15:0] rsp_line,
   output logic        rsp_last
);

   bundle_type       cur_ff, cur_in;
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             is_final;
   logic             take;
   event_type        ev;

   assign is_final = (idx_ff == IDX_W'(cur_ff.count - COUNT_W'(1)));
   assign take     = !busy_ff || (rsp_ready && is_final);
   assign q_pop    = take && !q_empty;

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (take) begin
         busy_in = !q_empty;
         idx_in  = '0;
         if (!q_empty) cur_in = q_head;
      end else if (rsp_ready) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   assign ev              = cur_ff.events[idx_ff];
   assign rsp_valid       = busy_ff;
   assign rsp_kind        = ev.kind;
   assign rsp_first_char  = ev.first_char;
   assign rsp_second_char = ev.second_char;
   assign rsp_column      = ev.column;
   assign rsp_line        = ev.line;
   assign rsp_last        = is_final;

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   `STT_ASSERT_IMPL(a_bundle_not_empty, clock, reset, busy_ff, cur_ff.count != '0, "empty bundle held in result stage")
   `STT_ASSERT_IMPL(a_index_in_bundle, clock, reset, busy_ff, idx_ff < IDX_W'(cur_ff.count), "event index past bundle end")
   `STT_ASSERT_NEXT(a_bundle_continues, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid && (idx_ff == $past(idx_ff) + IDX_W'(1)), "bundle cut short after a non-final transfer")

endmodule

FILE: rtl/source_text_tokenizer.sv
// Streaming source text tokenizer. Each accepted byte is classified in the
// cycle of its transfer and turned into a bundle of up to six events; only a
// non-empty bundle waits in a short queue. While rsp_ready is high, the result
// stage sends those events one transfer per cycle, so a byte that causes at most
// one event keeps a rate of one byte per clock, and a byte that causes n events
// takes n transfers on the result port. At the earliest, the first event of a
// byte is presented once its bundle has passed the queue and the result stage
// register. The input stalls only when the queue of QUEUE_DEPTH bundles is full.
// One lookahead byte is held inside, so most events belong to the previous byte;
// at end of input the block flushes and returns to its reset state. There is no
// clearing pass. Depends on stt_pkg, stt_front, stt_queue and stt_back.
`timescale 1ns / 1ps

module source_text_tokenizer import stt_pkg::*; #(
   parameter int TAB_WIDTH   = 4,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_first_char,
   output logic [7:0]  rsp_second_char,
   output logic [15:0] rsp_column,
   output logic [15:0] rsp_line,
   output logic        rsp_last
);

   logic       accept;
   logic       push;
   bundle_type push_data;
   logic       q_full;
   logic       q_empty;
   logic       q_pop;
   bundle_type q_head;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   stt_front #(
      .TAB_WIDTH(TAB_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .byte_value  (req_byte_value),
      .end_of_input(req_end_of_input),
      .push        (push),
      .push_data   (push_data)
   );

   stt_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   stt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_first_char (rsp_first_char),
      .rsp_second_char(rsp_second_char),
      .rsp_column     (rsp_column),
      .rsp_line       (rsp_line),
      .rsp_last       (rsp_last)
   );

endmodule

FILE: tb/sv/source_text_tokenizer_tb.sv
// Self-checking testbench for the source text tokenizer: predicts every event
// from the accepted bytes and checks each result transfer in order.
// Depends on stt_pkg and the source_text_tokenizer RTL.
`timescale 1ns / 1ps

module source_text_tokenizer_tb;
   import stt_pkg::*;

   localparam int TAIL_CYCLES    = 20;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_BYTES   = 450;

   // Predicts the events of the tokenizer and checks the results against them.
   class token_scoreboard;
      localparam int unsigned TAB_WIDTH = 4;

      typedef struct packed {
         event_type token;
         logic      last;
      } expected_token_type;

      logic [7:0]  held_byte;
      bit          held_valid;
      bit          in_line_comment;
      bit          in_block_comment;
      bit          in_quotes;
      bit          word_open;
      int unsigned line_count;
      int unsigned column_count;
      int unsigned word_start_column;

      expected_token_type expected_tokens[$];
      event_type          step_tokens[$];
      int                 mismatches;
      int                 results_seen;

      function new();
         restart();
         mismatches   = 0;
         results_seen = 0;
      endfunction

      function void restart();
         held_byte         = CHAR_NUL;
         held_valid        = 1'b0;
         in_line_comment   = 1'b0;
         in_block_comment  = 1'b0;
         in_quotes         = 1'b0;
         word_open         = 1'b0;
         line_count        = 1;
         column_count      = 1;
         word_start_column = 1;
      endfunction

      function int pending();
         return expected_tokens.size();
      endfunction

      function void emit(logic [1:0] kind, logic [7:0] first_char, logic [7:0] second_char,
                         int unsigned col, int unsigned ln);
         event_type token;
         token = {kind, first_char, second_char, col[15:0], ln[15:0]};
         if (step_tokens.size() < MAX_EVENTS) step_tokens.insert(step_tokens.size(), token);
      endfunction

      function void advance_column(int unsigned amount);
         int unsigned sum;
         sum = column_count + amount;
         column_count = (sum > POS_MAX) ? POS_MAX : sum;
      endfunction

      function void step_column(logic [7:0] c);
         int unsigned base;
         if (c == CHAR_TAB) begin
            base = (column_count != 0) ? column_count - 1 : 0;
            advance_column(TAB_WIDTH - base % TAB_WIDTH);
         end else begin
            advance_column(1);
         end
      endfunction

      function void close_word();
         if (word_open) begin
            emit(KIND_WORD_END, CHAR_NUL, CHAR_NUL, word_start_column, line_count);
            word_open = 1'b0;
         end
      endfunction

      function bit is_pair(logic [7:0] a, logic [7:0] b);
         if (b == "=") begin
            case (a)
               "=", "!", "+", "-", "*", "/", "&", "|", ">", "<": return 1'b1;
               default: return 1'b0;
            endcase
         end
         if (a == b) begin
            case (a)
               "&", "|", "+", "-", ">", "<": return 1'b1;
               default: return 1'b0;
            endcase
         end
         return (a == "-") && (b == ">");
      endfunction

      function bit is_single(logic [7:0] a);
         case (a)
            "{", "}", "(", ")", "[", "]", ">", "<", ",", ";", ":",
            "+", "-", "*", "/", "%", "&", "|", "!", "~", "=", "?": return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      // Classifies c0 with lookahead c1 and returns how many bytes it used.
      function int classify(logic [7:0] c0, logic [7:0] c1);
         if (c0 == CHAR_CR && c1 == CHAR_LF) begin
            close_word();
            emit(KIND_EOL, CHAR_NUL, CHAR_NUL, 0, 0);
            if (line_count < POS_MAX) line_count++;
            column_count    = 1;
            in_line_comment = 1'b0;
            return 2;
         end
         if (c0 == CHAR_STAR && c1 == CHAR_SLASH) begin
            advance_column(2);
            in_block_comment = 1'b0;
            return 2;
         end
         if (in_line_comment || in_block_comment) begin
            step_column(c0);
            return 1;
         end
         if (c0 == CHAR_SLASH && (c1 == CHAR_SLASH || c1 == CHAR_STAR)) begin
            advance_column(2);
            if (c1 == CHAR_SLASH) in_line_comment = 1'b1;
            else in_block_comment = 1'b1;
            return 2;
         end
         if (c0 == CHAR_QUOTE) begin
            in_quotes = !in_quotes;
            // A closing quote belongs to the word and then ends it.
            if (!in_quotes) begin
               word_open = 1'b1;
               emit(KIND_WORD_CHAR, c0, CHAR_NUL, word_start_column, line_count);
               close_word();
               advance_column(1);
               return 1;
            end
         end
         if (!in_quotes) begin
            if (c0 == CHAR_SPACE || c0 == CHAR_TAB) begin
               close_word();
               step_column(c0);
               return 1;
            end
            if (is_pair(c0, c1)) begin
               close_word();
               emit(KIND_OPERATOR, c0, c1, column_count, line_count);
               advance_column(2);
               return 2;
            end
            if (is_single(c0)) begin
               close_word();
               emit(KIND_OPERATOR, c0, CHAR_NUL, column_count, line_count);
               advance_column(1);
               return 1;
            end
         end
         if (!word_open) begin
            word_start_column = column_count;
            word_open         = 1'b1;
         end
         emit(KIND_WORD_CHAR, c0, CHAR_NUL, word_start_column, line_count);
         step_column(c0);
         return 1;
      endfunction

      function void note_byte(logic [7:0] value, logic end_of_text);
         expected_token_type entry;
         step_tokens = {};
         if (held_valid) begin
            if (classify(held_byte, value) == 2) held_valid = 1'b0;
            else held_byte = value;
         end else begin
            held_byte  = value;
            held_valid = 1'b1;
         end
         if (end_of_text) begin
            if (held_valid) begin
               void'(classify(held_byte, CHAR_NUL));
               held_valid = 1'b0;
            end
            close_word();
            emit(KIND_EOL, CHAR_NUL, CHAR_NUL, 0, 0);
            restart();
         end
         foreach (step_tokens[i]) begin
            entry.token = step_tokens[i];
            entry.last  = (i == step_tokens.size() - 1);
            expected_tokens.insert(expected_tokens.size(), entry);
         end
      endfunction

      task report(string what);
         if (mismatches < 25) $display("MISMATCH %s", what);
         mismatches++;
      endtask

      task check_event(event_type got, logic got_last);
         expected_token_type want;
         results_seen++;
         if (expected_tokens.size() == 0) begin
            report($sformatf("result %0d not expected: kind %0d chars %02h/%02h col %0d line %0d",
                             results_seen, got.kind, got.first_char, got.second_char,
                             got.column, got.line));
            return;
         end
         want = expected_tokens.pop_front();
         if (got.kind !== want.token.kind || got.first_char !== want.token.first_char ||
             got.second_char !== want.token.second_char || got.column !== want.token.column ||
             got.line !== want.token.line || got_last !== want.last) begin
            report($sformatf({"result %0d: got kind %0d chars %02h/%02h col %0d line %0d last %0b,",
                              " want kind %0d chars %02h/%02h col %0d line %0d last %0b"},
                             results_seen, got.kind, got.first_char, got.second_char,
                             got.column, got.line, got_last, want.token.kind,
                             want.token.first_char, want.token.second_char,
                             want.token.column, want.token.line, want.last));
         end
      endtask

      task report_leftovers();
         if (expected_tokens.size() != 0)
            report($sformatf("%0d expected results never arrived", expected_tokens.size()));
      endtask
   endclass

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [7:0]  req_byte_value   = 8'h00;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_first_char;
   logic [7:0]  rsp_second_char;
   logic [15:0] rsp_column;
   logic [15:0] rsp_line;
   logic        rsp_last;

   token_scoreboard board;
   logic [7:0]      text_bytes[$];
   bit              hold_request = 1'b0;
   int              bytes_sent   = 0;
   int              burst_left   = 0;

   source_text_tokenizer #(
      .TAB_WIDTH(token_scoreboard::TAB_WIDTH)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_value  (req_byte_value),
      .req_end_of_input(req_end_of_input),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_first_char  (rsp_first_char),
      .rsp_second_char (rsp_second_char),
      .rsp_column      (rsp_column),
      .rsp_line        (rsp_line),
      .rsp_last        (rsp_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Both channels are observed here, so a byte is always noted before any
   // result that it can cause.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_byte(req_byte_value, req_end_of_input);
         if (rsp_valid && rsp_ready)
            board.check_event({rsp_kind, rsp_first_char, rsp_second_char, rsp_column, rsp_line},
                              rsp_last);
      end
   end

   // Receiver: segments of steady, busy and sparse acceptance, plus one long hold.
   initial begin : receiver
      int mode;
      int span;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(0, 2);
         span = $urandom_range(1, 40);
         repeat (span) begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      @(negedge reset);
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send_byte(input logic [7:0] value, input logic end_of_text);
      int gap;
      req_valid        <= 1'b1;
      req_byte_value   <= value;
      req_end_of_input <= end_of_text;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 31);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_text();
      foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
      text_bytes = {};
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   function automatic void add_byte(logic [7:0] value);
      text_bytes.insert(text_bytes.size(), value);
   endfunction

   function automatic void add_string(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic void add_line_break();
      add_byte(CHAR_CR);
      add_byte(CHAR_LF);
   endfunction

   function automatic void add_random_token();
      string word_chars;
      string singles;
      string pairs;
      int    pick;
      int    k;
      word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.#$";
      singles    = "{}()[]><,;:+-*/%&|!~=?";
      pairs      = "==!=+=-=*=/=&=|=>=<=&&||++-->><<->";
      pick       = $urandom_range(0, 99);
      if (pick < 30) begin
         repeat ($urandom_range(1, 6))
            add_byte(word_chars[$urandom_range(0, word_chars.len() - 1)]);
      end else if (pick < 40) begin
         add_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
      end else if (pick < 48) begin
         add_line_break();
      end else if (pick < 51) begin
         // A CR or LF on its own is an ordinary word character.
         add_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
      end else if (pick < 63) begin
         add_byte(singles[$urandom_range(0, singles.len() - 1)]);
      end else if (pick < 73) begin
         k = $urandom_range(0, pairs.len() / 2 - 1);
         add_byte(pairs[2 * k]);
         add_byte(pairs[2 * k + 1]);
      end else if (pick < 78) begin
         add_string("//");
      end else if (pick < 83) begin
         add_string("/*");
      end else if (pick < 88) begin
         add_string("*/");
      end else if (pick < 94) begin
         add_byte(CHAR_QUOTE);
      end else if (pick < 97) begin
         add_byte(CHAR_NUL);
      end else begin
         add_byte(8'($urandom_range(0, 255)));
      end
   endfunction

   initial begin : stimulus
      int random_goal;
      bit drained_midway;
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Words, a top byte, tab, arrow, a quote left open across a line break,
      // a line comment, a block comment and a zero byte as lookahead.
      add_string("a");
      add_byte(8'hFF);
      add_string("\t->(\"q");
      add_line_break();
      add_string("\"//x");
      add_line_break();
      add_string("/*y*/z=");
      add_byte(CHAR_NUL);
      add_string("=");
      send_text();
      add_string("+");
      send_text();
      wait_drained();

      // The receiver now holds off for a long time while bytes keep coming.
      hold_request   = 1'b1;
      random_goal    = bytes_sent + RANDOM_BYTES;
      drained_midway = 1'b0;
      while (bytes_sent < random_goal) begin
         if ($urandom_range(0, 9) == 0) begin
            add_byte(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 12)) add_random_token();
         end
         send_text();
         if (!drained_midway && bytes_sent >= random_goal - RANDOM_BYTES / 2) begin
            wait_drained();
            drained_midway = 1'b1;
         end
      end

      wait_drained();
      board.report_leftovers();
      if (board.mismatches == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
